[sv/cpu_alu_8bit_with_flags_unit_defines.svh]
// Assertion macros shared by the ALU RTL.
// Depends on a clock named clk and an active-high reset named rst in scope.
`ifndef CPU_ALU_8BIT_WITH_FLAGS_UNIT_DEFINES_SVH
`define CPU_ALU_8BIT_WITH_FLAGS_UNIT_DEFINES_SVH

// Check a property on every clock edge outside reset
`define ALU8F_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define ALU8F_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/alu8f_pkg.sv]
// Shared types and constants for the 8-bit ALU with flags.
// No dependencies.
`default_nettype none

package alu8f_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned NibbleW = 4;
  localparam int unsigned WordW   = 16;
  localparam int unsigned OpW     = 3;

  // Operation codes
  typedef enum logic [OpW-1:0] {
    OP_ADD = 3'd0,
    OP_ADC = 3'd1,
    OP_SUB = 3'd2,
    OP_SBC = 3'd3,
    OP_AND = 3'd4,
    OP_XOR = 3'd5,
    OP_OR  = 3'd6,
    OP_ADDSP = 3'd7
  } alu8f_op_t;

  // Flag group, zero in the top bit down to carry in the bottom bit
  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } alu8f_flags_t;

  localparam alu8f_flags_t FlagsReset = '{z: 1'b0, n: 1'b0, h: 1'b0, c: 1'b0};

endpackage

`default_nettype wire

[sv/alu8f_core.sv]
// Combinational datapath of the ALU: result and new flags for one request.
// Depends on alu8f_pkg.
`default_nettype none

module alu8f_core
  import alu8f_pkg::*;
(
  input  wire alu8f_op_t          op,
  input  wire logic [ByteW-1:0]   a,
  input  wire logic [ByteW-1:0]   b,
  input  wire logic [WordW-1:0]   sp,
  input  wire logic               cin,
  output logic      [WordW-1:0]   result,
  output alu8f_flags_t            flags
);

  logic             ci;
  logic [ByteW:0]   sum9;
  logic [NibbleW:0] sum5;
  logic [ByteW:0]   diff9;
  logic [NibbleW:0] diff5;
  logic [WordW-1:0] sp_sum;
  logic [ByteW:0]   sp_low9;
  logic [NibbleW:0] sp_low5;

  // Carry-in only for the with-carry forms
  assign ci = ((op == OP_ADC) || (op == OP_SBC)) ? cin : 1'b0;

  // Add and subtract with their nibble counterparts for half-carry
  assign sum9  = {1'b0, a} + {1'b0, b} + {{ByteW{1'b0}}, ci};
  assign sum5  = {1'b0, a[NibbleW-1:0]} + {1'b0, b[NibbleW-1:0]} + {{NibbleW{1'b0}}, ci};
  assign diff9 = {1'b0, a} - {1'b0, b} - {{ByteW{1'b0}}, ci};
  assign diff5 = {1'b0, a[NibbleW-1:0]} - {1'b0, b[NibbleW-1:0]} - {{NibbleW{1'b0}}, ci};

  // Stack pointer plus sign-extended offset; flags from unsigned low sums
  assign sp_sum  = sp + {{(WordW-ByteW){b[ByteW-1]}}, b};
  assign sp_low9 = {1'b0, b} + {1'b0, sp[ByteW-1:0]};
  assign sp_low5 = {1'b0, b[NibbleW-1:0]} + {1'b0, sp[NibbleW-1:0]};

  // Select result and flags per operation
  always_comb begin
    result = '0;
    flags  = FlagsReset;
    unique case (op)
      OP_ADD, OP_ADC: begin
        result  = {{(WordW-ByteW){1'b0}}, sum9[ByteW-1:0]};
        flags.h = sum5[NibbleW];
        flags.c = sum9[ByteW];
      end
      OP_SUB, OP_SBC: begin
        result  = {{(WordW-ByteW){1'b0}}, diff9[ByteW-1:0]};
        flags.n = 1'b1;
        flags.h = diff5[NibbleW];
        flags.c = diff9[ByteW];
      end
      OP_AND: begin
        result  = {{(WordW-ByteW){1'b0}}, a & b};
        flags.h = 1'b1;
      end
      OP_XOR: begin
        result = {{(WordW-ByteW){1'b0}}, a ^ b};
      end
      OP_OR: begin
        result = {{(WordW-ByteW){1'b0}}, a | b};
      end
      OP_ADDSP: begin
        result  = sp_sum;
        flags.h = sp_low5[NibbleW];
        flags.c = sp_low9[ByteW];
      end
      default: begin
        result = '0;
      end
    endcase
    // Zero flag from the byte result, always cleared by the pointer add
    flags.z = (op != OP_ADDSP) && (result == '0);
  end

endmodule

`default_nettype wire

[sv/cpu_alu_8bit_with_flags_unit.sv]
// A request passes the input register, then the result register.
// Throughput: one request per cycle while the receiver does not stall,
// kept by the combinational datapath between them and the carry feedback.
// The result register takes a new value while the previous one waits only
// if it is being taken in the same cycle. Reset (rst, synchronous, active
// high) empties both registers and clears the flag register.
`default_nettype none
`include "cpu_alu_8bit_with_flags_unit_defines.svh"

module cpu_alu_8bit_with_flags_unit
  import alu8f_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // tdata: operand_a [7:0], operand_b [15:8], stack_pointer [31:16]
  input  wire logic [31:0] s_axis_tdata,
  // tuser: opcode [2:0]
  input  wire logic [2:0]  s_axis_tuser,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: result [15:0], zero_flag [16], subtract_flag [17],
  //        half_carry_flag [18], carry_flag [19], zero pad [23:20]
  output logic [23:0]      m_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready
);

  // Input register
  logic             s1_valid;
  alu8f_op_t        s1_op;
  logic [ByteW-1:0] s1_a;
  logic [ByteW-1:0] s1_b;
  logic [WordW-1:0] s1_sp;

  // Result register and flag state
  logic [WordW-1:0] out_result;
  alu8f_flags_t     out_flags;
  alu8f_flags_t     flags;

  logic             advance;
  logic [WordW-1:0] core_result;
  alu8f_flags_t     core_flags;

  // Move the staged request to the result register when it is free or draining
  assign advance       = s1_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_valid || advance;

  alu8f_core u_core (
    .op     (s1_op),
    .a      (s1_a),
    .b      (s1_b),
    .sp     (s1_sp),
    .cin    (flags.c),
    .result (core_result),
    .flags  (core_flags)
  );

  // Control state: valid bits and flag register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
      flags         <= FlagsReset;
    end else begin
      if (s_axis_tready) begin
        s1_valid <= s_axis_tvalid;
      end
      if (advance) begin
        m_axis_tvalid <= 1'b1;
        flags         <= core_flags;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Payload: capture request, then result
  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      s1_op <= alu8f_op_t'(s_axis_tuser[OpW-1:0]);
      s1_a  <= s_axis_tdata[ByteW-1:0];
      s1_b  <= s_axis_tdata[2*ByteW-1:ByteW];
      s1_sp <= s_axis_tdata[2*ByteW+WordW-1:2*ByteW];
    end
    if (advance) begin
      out_result <= core_result;
      out_flags  <= core_flags;
    end
  end

  assign m_axis_tdata = {4'b0000, out_flags.c, out_flags.h, out_flags.n, out_flags.z,
                         out_result};

  // Checks
  `ALU8F_ASSERT_ALWAYS(a_reset_empty, rst |=> (!s1_valid && !m_axis_tvalid && flags == FlagsReset), "pipeline not empty after reset")
  `ALU8F_ASSERT(a_advance_shows, advance |=> (m_axis_tvalid && out_flags == flags), "result or flag register missed an update")
  `ALU8F_ASSERT(a_stage_holds, (s1_valid && !advance) |=> (s1_valid && $stable(s1_a) && $stable(s1_sp)), "staged request lost while stalled")
  `ALU8F_ASSERT(a_flags_track, (m_axis_tvalid && !advance) |=> (flags == out_flags), "flag register differs from last result")

endmodule

`default_nettype wire

[sim/tb_cpu_alu_8bit_with_flags_unit.sv]
// Self-checking bench for the 8-bit ALU with flag register, stream in and out.
// Depends on alu8f_pkg and cpu_alu_8bit_with_flags_unit; predicts each result,
// or takes it from the directed table, and compares it with the output, in order.
`timescale 1ns / 1ps

module tb_cpu_alu_8bit_with_flags_unit;
  import alu8f_pkg::*;

  localparam int unsigned RandomCount = 650;
  localparam int unsigned DirCount    = 23;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned IdlePct     = 8;
  localparam int unsigned CalmFirst   = 100;
  localparam int unsigned CalmLast    = 250;
  localparam int unsigned HoldAt      = 320;
  localparam int unsigned HoldCycles  = 80;
  localparam int unsigned DrainAt     = 480;

  typedef struct packed {
    logic [15:0]  value;
    alu8f_flags_t flags;
  } alu_out_t;

  typedef struct {
    alu8f_op_t    op;
    logic [7:0]   a;
    logic [7:0]   b;
    logic [15:0]  sp;
    bit           typed;
    logic [15:0]  value;
    alu8f_flags_t flags;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic [31:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;

  alu8f_flags_t model_flags;
  alu_out_t     pending_results[$];
  stim_row_t    dir_rows [DirCount];
  int unsigned  requests_taken;
  int unsigned  results_seen;
  int unsigned  mismatches;
  int unsigned  cycle_count;
  bit           calm;

  cpu_alu_8bit_with_flags_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  // 2 ns clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Compute the next result and advance the flag register
  function automatic alu_out_t predict_alu(input alu8f_op_t op, input logic [7:0] a,
                                           input logic [7:0] b, input logic [15:0] sp);
    alu_out_t   r;
    logic       cin;
    logic [4:0] nib;
    logic [8:0] wide;
    r = '0;
    cin = (op == OP_ADC || op == OP_SBC) ? model_flags.c : 1'b0;
    case (op)
      OP_ADD, OP_ADC: begin
        nib = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'b0000, cin};
        wide = {1'b0, a} + {1'b0, b} + {8'h00, cin};
        r.flags.h = nib[4];
        r.flags.c = wide[8];
        r.value = {8'h00, wide[7:0]};
      end
      OP_SUB, OP_SBC: begin
        r.flags.n = 1'b1;
        r.flags.h = {1'b0, a[3:0]} < ({1'b0, b[3:0]} + {4'b0000, cin});
        r.flags.c = {1'b0, a} < ({1'b0, b} + {8'h00, cin});
        wide = {1'b0, a} - {1'b0, b} - {8'h00, cin};
        r.value = {8'h00, wide[7:0]};
      end
      OP_AND: begin
        r.value = {8'h00, a & b};
        r.flags.h = 1'b1;
      end
      OP_XOR: r.value = {8'h00, a ^ b};
      OP_OR:  r.value = {8'h00, a | b};
      default: begin
        // Flags come from the unsigned low byte, the sum from the signed offset
        nib = {1'b0, b[3:0]} + {1'b0, sp[3:0]};
        wide = {1'b0, b} + {1'b0, sp[7:0]};
        r.flags.h = nib[4];
        r.flags.c = wide[8];
        r.value = sp + {{8{b[7]}}, b};
      end
    endcase
    r.flags.z = (op == OP_ADDSP) ? 1'b0 : (r.value == 16'h0000);
    model_flags = r.flags;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch in %s of result %0d: got %h, expected %h",
             field, results_seen, got, want);
    mismatches++;
  endtask

  // Offer one request, with random gaps, and record its expectation on accept
  task automatic offer_request(input alu8f_op_t op, input logic [7:0] a, input logic [7:0] b,
                               input logic [15:0] sp, input bit typed,
                               input alu_out_t typed_out);
    alu_out_t predicted;
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < IdlePct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {sp, b, a};
    do @(posedge clk); while (!s_axis_tready);
    predicted = predict_alu(op, a, b, sp);
    pending_results.push_back(typed ? typed_out : predicted);
    requests_taken++;
  endtask

  // Byte with a bias toward the edges of the range
  function automatic logic [7:0] pick_byte();
    logic [7:0] edges [6];
    edges = '{8'h00, 8'hff, 8'h0f, 8'hf0, 8'h80, 8'h7f};
    if ($urandom_range(0, 3) == 0) return edges[$urandom_range(0, 5)];
    return 8'($urandom);
  endfunction

  // Receiver: random stalls, one long hold-off, and a calm stretch
  initial begin
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && requests_taken >= HoldAt) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= IdlePct);
      end
    end
  end

  // Check each returned result against the oldest expectation
  always @(posedge clk) begin
    alu_out_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata[15:0], 16'h0000);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[15:0] !== want.value)
          report_mismatch("result", m_axis_tdata[15:0], want.value);
        if (m_axis_tdata[16] !== want.flags.z)
          report_mismatch("zero_flag", 16'(m_axis_tdata[16]), 16'(want.flags.z));
        if (m_axis_tdata[17] !== want.flags.n)
          report_mismatch("subtract_flag", 16'(m_axis_tdata[17]), 16'(want.flags.n));
        if (m_axis_tdata[18] !== want.flags.h)
          report_mismatch("half_carry_flag", 16'(m_axis_tdata[18]), 16'(want.flags.h));
        if (m_axis_tdata[19] !== want.flags.c)
          report_mismatch("carry_flag", 16'(m_axis_tdata[19]), 16'(want.flags.c));
      end
      results_seen++;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Sender: reset, directed table, random requests, then drain and verdict
  initial begin
    alu8f_op_t  op;
    logic [7:0] a;
    logic [7:0] b;
    logic [15:0] sp;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = OP_ADD;
    model_flags = FlagsReset;
    requests_taken = 0;
    results_seen = 0;
    mismatches = 0;
    cycle_count = 0;
    calm = 1'b0;

    // Flags column: zero, subtract, half-carry, carry from the top bit down
    dir_rows = '{
      '{OP_ADC,   8'hff, 8'h01, 16'h0000, 1'b1, 16'h0000, 4'b1011},
      '{OP_ADC,   8'h00, 8'h00, 16'hffff, 1'b1, 16'h0001, 4'b0000},
      '{OP_ADD,   8'hff, 8'hff, 16'h0000, 1'b1, 16'h00fe, 4'b0011},
      '{OP_SBC,   8'h00, 8'h00, 16'h0000, 1'b1, 16'h00ff, 4'b0111},
      '{OP_SUB,   8'h00, 8'h01, 16'h0000, 1'b0, 16'h0000, 4'b0000},
      '{OP_SUB,   8'h55, 8'h55, 16'h0000, 1'b1, 16'h0000, 4'b1100},
      '{OP_AND,   8'hff, 8'h00, 16'h0000, 1'b1, 16'h0000, 4'b1010},
      '{OP_AND,   8'hff, 8'hff, 16'hffff, 1'b0, 16'h0000, 4'b0000},
      '{OP_XOR,   8'haa, 8'h55, 16'h0000, 1'b1, 16'h00ff, 4'b0000},
      '{OP_XOR,   8'h5a, 8'h5a, 16'h0000, 1'b0, 16'h0000, 4'b0000},
      '{OP_OR,    8'h00, 8'h00, 16'h0000, 1'b1, 16'h0000, 4'b1000},
      '{OP_OR,    8'hf0, 8'h0f, 16'h0000, 1'b0, 16'h0000, 4'b0000},
      '{OP_ADDSP, 8'ha5, 8'h01, 16'hffff, 1'b1, 16'h0000, 4'b0011},
      '{OP_ADDSP, 8'h00, 8'h80, 16'h0000, 1'b1, 16'hff80, 4'b0000},
      '{OP_ADDSP, 8'hff, 8'hff, 16'h0001, 1'b0, 16'h0000, 4'b0000},
      '{OP_ADDSP, 8'h5a, 8'h00, 16'hffff, 1'b0, 16'h0000, 4'b0000},
      '{OP_ADC,   8'hff, 8'hff, 16'h0000, 1'b0, 16'h0000, 4'b0000},
      '{OP_ADC,   8'h0f, 8'h00, 16'h0000, 1'b0, 16'h0000, 4'b0000},
      '{OP_SBC,   8'h10, 8'h01, 16'h0000, 1'b0, 16'h0000, 4'b0000},
      '{OP_SBC,   8'hff, 8'hff, 16'h0000, 1'b0, 16'h0000, 4'b0000},
      '{OP_ADD,   8'h00, 8'h00, 16'h0000, 1'b0, 16'h0000, 4'b0000},
      '{OP_ADDSP, 8'hff, 8'h7f, 16'h8081, 1'b0, 16'h0000, 4'b0000},
      '{OP_SUB,   8'hff, 8'hff, 16'hffff, 1'b0, 16'h0000, 4'b0000}
    };

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed requests
    foreach (dir_rows[i])
      offer_request(dir_rows[i].op, dir_rows[i].a, dir_rows[i].b, dir_rows[i].sp,
                    dir_rows[i].typed, {dir_rows[i].value, dir_rows[i].flags});

    // Random requests
    for (int unsigned k = 0; k < RandomCount; k++) begin
      calm = (k >= CalmFirst && k < CalmLast);
      // Drop the request line and let the pipeline run dry once before carrying on
      if (k == DrainAt) begin
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
      op = alu8f_op_t'($urandom_range(0, 7));
      a = pick_byte();
      b = pick_byte();
      case ($urandom_range(0, 5))
        0: sp = 16'h0000;
        1: sp = 16'hffff;
        2: sp = {8'($urandom), 8'hff};
        default: sp = 16'($urandom);
      endcase
      offer_request(op, a, b, sp, 1'b0, '0);
    end
    calm = 1'b0;
    @(negedge clk);
    s_axis_tvalid <= 1'b0;

    // Drain, then leave room for anything stray
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
